// ===== design/lpr_pkg.sv =====
// Shared types and constants for the LRU page replacement unit.
// Holds the scan record and frame update structs and the control state enum.
// No dependencies.
package lpr_pkg;

  localparam int PAGE_W     = 16;  // width of the page number port
  localparam int AGE_W      = 16;  // width of a frame age counter
  localparam int IDX_W      = 6;   // frame index width, covers up to 64 frames
  localparam int LIM_W      = 7;   // active frame count width, covers up to 64
  localparam int CFG_W      = 5;   // width of the active_entries register
  localparam int TOTAL_W    = 32;  // width of the fault counter
  localparam int SLOT_OUT_W = 4;   // width of the reported slot

  localparam logic [AGE_W-1:0]   AGE_MAX      = {AGE_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};
  localparam logic [CFG_W-1:0]   ACTIVE_RESET = 5'd16;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } lpr_state_t;

  // Record that walks the frame chain, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic [PAGE_W-1:0] key;
    logic [LIM_W-1:0]  lim;
    logic             hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [AGE_W-1:0]  best_age;
    logic [IDX_W-1:0]  best_idx;
  } scan_rec_t;

  // Update broadcast to every frame once the decision is made.
  typedef struct packed {
    logic             en;
    logic             write;
    logic [IDX_W-1:0]  slot;
    logic [PAGE_W-1:0] key;
    logic [LIM_W-1:0]  lim;
  } frame_upd_t;

endpackage

// ===== design/lpr_cell.sv =====
// One frame of the page table: page tag, valid bit and age counter.
// Passes the scan record to its neighbor every cycle and applies updates.
// Depends on lpr_pkg.
module lpr_cell #(
  parameter int IDX      = 0,
  parameter int CMP_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpr_pkg::scan_rec_t  rec_in,
  input  lpr_pkg::frame_upd_t upd,
  output lpr_pkg::scan_rec_t  rec_out
);
  import lpr_pkg::*;

  logic [CMP_BITS-1:0] page_r;
  logic                valid_r;
  logic [AGE_W-1:0]    age_r;
  scan_rec_t           rec_r;
  scan_rec_t           rec_nxt;

  logic             scan_in_range;
  logic             upd_in_range;
  logic             match;
  logic [AGE_W-1:0] aged;

  assign scan_in_range = LIM_W'(IDX) < rec_in.lim;
  assign upd_in_range  = LIM_W'(IDX) < upd.lim;
  assign match = scan_in_range && valid_r && (page_r == rec_in.key[CMP_BITS-1:0]);

  // Age as it will be after this reference, before the victim is chosen
  assign aged = (scan_in_range && valid_r && (age_r != AGE_MAX)) ? age_r + 1'b1 : age_r;

  always_comb begin
    rec_nxt = rec_in;
    if (match && !rec_in.hit) begin
      rec_nxt.hit     = 1'b1;
      rec_nxt.hit_idx = IDX_W'(IDX);
    end
    if (scan_in_range && (aged > rec_in.best_age)) begin
      rec_nxt.best_age = aged;
      rec_nxt.best_idx = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.valid <= 1'b0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
    end else if (upd.en) begin
      if (upd.slot == IDX_W'(IDX)) begin
        age_r <= '0;
        if (upd.write) begin
          valid_r <= 1'b1;
        end
      end else if (upd_in_range && valid_r && (age_r != AGE_MAX)) begin
        age_r <= age_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.write && (upd.slot == IDX_W'(IDX))) begin
      page_r <= upd.key[CMP_BITS-1:0];
    end
  end

  assign rec_out = rec_r;

endmodule

// ===== design/lpr_ctrl.sv =====
// Control for the LRU page replacement unit: handshake, active count register,
// fill count, fault counter, replacement decision and result registers.
// Depends on lpr_pkg.
module lpr_ctrl #(
  parameter int ENTRIES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [lpr_pkg::PAGE_W-1:0]            in_page_number,
  input  logic                                  cfg_wr_en,
  input  logic [lpr_pkg::CFG_W-1:0]             cfg_wr_data,
  output lpr_pkg::scan_rec_t                    head,
  input  lpr_pkg::scan_rec_t                    tail,
  output lpr_pkg::frame_upd_t                   upd,
  output logic                                  out_strobe,
  output logic                                  out_fault,
  output logic [lpr_pkg::SLOT_OUT_W-1:0]        out_slot,
  output logic                                  out_evicted,
  output logic [lpr_pkg::TOTAL_W-1:0]           out_fault_total
);
  import lpr_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);

  lpr_state_t state_r, state_nxt;

  logic [CFG_W-1:0]   active_r;
  logic [CNT_W-1:0]   filled_r, filled_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]   lim;
  logic               accept;
  logic               done;
  logic               fill;
  logic [IDX_W-1:0]   slot;

  logic                  strobe_r;
  logic                  fault_r;
  logic [SLOT_OUT_W-1:0] slot_r;
  logic                  evicted_r;

  // Clamp the active count to 1..ENTRIES
  always_comb begin
    if (active_r == '0) begin
      lim = CNT_W'(1);
    end else if (int'(active_r) > ENTRIES) begin
      lim = CNT_W'(ENTRIES);
    end else begin
      lim = CNT_W'(active_r);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: if (tail.valid) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy   = 1'b1;
    accept = 1'b0;
    done   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_SCAN: done = tail.valid;
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    head          = '0;
    head.valid    = accept;
    head.key      = in_page_number;
    head.lim      = LIM_W'(lim);
  end

  // Replacement decision once the record has passed every frame
  always_comb begin
    fill = !tail.hit && (filled_r < lim);
    if (tail.hit) begin
      slot = tail.hit_idx;
    end else if (fill) begin
      slot = IDX_W'(filled_r);
    end else begin
      slot = tail.best_idx;
    end

    upd.en    = done;
    upd.write = !tail.hit;
    upd.slot  = slot;
    upd.key   = tail.key;
    upd.lim   = tail.lim;

    filled_nxt = filled_r;
    if (done && fill) begin
      filled_nxt = filled_r + 1'b1;
    end
    total_nxt = total_r;
    if (done && !tail.hit && (total_r != TOTAL_MAX)) begin
      total_nxt = total_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= ACTIVE_RESET;
      filled_r <= '0;
      total_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
      total_r  <= total_nxt;
      strobe_r <= done;
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      fault_r   <= !tail.hit;
      slot_r    <= SLOT_OUT_W'(slot);
      evicted_r <= !tail.hit && !fill;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_fault       = fault_r;
  assign out_slot        = slot_r;
  assign out_evicted     = evicted_r;
  assign out_fault_total = total_r;

endmodule

// ===== design/lru_page_replacement_unit.sv =====
// Top level of the LRU page replacement unit: a chain of frame cells and
// the controller. Depends on lpr_pkg, lpr_cell and lpr_ctrl.
//
// Usage:
//   A page reference is a transaction taken at a rising edge where start is
//   high and busy is low; in_page_number carries the page. The reference walks
//   the chain of frames, one frame per cycle, collecting the first hit and the
//   oldest frame. The edge after it leaves the last frame applies the update
//   and registers the result, which shows on out_* for one cycle with
//   out_strobe high.
//   out_strobe rises in the same cycle that busy drops, so a new reference is
//   not taken until the previous one has left the frame chain; the walk
//   through the frame chain sets the pace of references.
//   cfg_wr_en/cfg_wr_data write the active frame count; write it only while
//   busy is low and no result is pending. The table is not cleared by it.
//   Reset (rst_n low, synchronous) empties the table, clears the ages, the
//   fill count and the fault total, and sets the active count to 16.
//   The receiver cannot stall: every result must be taken in its strobe cycle.
module lru_page_replacement_unit #(
  parameter int ENTRIES   = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lpr_pkg::PAGE_W-1:0]      in_page_number,
  input  logic                            cfg_wr_en,
  input  logic [lpr_pkg::CFG_W-1:0]       cfg_wr_data,
  output logic                            out_strobe,
  output logic                            out_fault,
  output logic [lpr_pkg::SLOT_OUT_W-1:0]  out_slot,
  output logic                            out_evicted,
  output logic [lpr_pkg::TOTAL_W-1:0]     out_fault_total
);
  import lpr_pkg::*;

  localparam int CMP_BITS = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

  scan_rec_t  chain [ENTRIES+1];
  frame_upd_t upd;

  lpr_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_page_number (in_page_number),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .head           (chain[0]),
    .tail           (chain[ENTRIES]),
    .upd            (upd),
    .out_strobe     (out_strobe),
    .out_fault      (out_fault),
    .out_slot       (out_slot),
    .out_evicted    (out_evicted),
    .out_fault_total(out_fault_total)
  );

  for (genvar k = 0; k < ENTRIES; k++) begin : g_frame
    lpr_cell #(
      .IDX     (k),
      .CMP_BITS(CMP_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .rec_in (chain[k]),
      .upd    (upd),
      .rec_out(chain[k+1])
    );
  end

endmodule

// ===== tb/sv/lru_page_replacement_checker.sv =====
// Checker for the LRU page replacement unit: watches the reference, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on lpr_pkg.
module lru_page_replacement_checker #(
  parameter int ENTRIES   = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [lpr_pkg::PAGE_W-1:0]      in_page_number,
  input  logic                            cfg_wr_en,
  input  logic [lpr_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                            out_strobe,
  input  logic                            out_fault,
  input  logic [lpr_pkg::SLOT_OUT_W-1:0]  out_slot,
  input  logic                            out_evicted,
  input  logic [lpr_pkg::TOTAL_W-1:0]     out_fault_total,
  output int                              mismatches,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpr_pkg::*;

  typedef struct packed {
    logic                  fault;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
    logic [TOTAL_W-1:0]    total;
  } page_result_t;

  localparam logic [PAGE_W-1:0] PAGE_MASK = PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);

  logic [PAGE_W-1:0]  frame_page [ENTRIES];
  logic               frame_used [ENTRIES];
  logic [AGE_W-1:0]   frame_age  [ENTRIES];
  int unsigned        fill_level;
  logic [TOTAL_W-1:0] faults_seen;
  logic [CFG_W-1:0]   active_cfg;
  page_result_t       expected_refs [$];

  // Zero means one frame, anything above the table size means all of it.
  function automatic int unsigned frames_in_use();
    int unsigned lim;
    lim = 32'(active_cfg);
    if (lim == 0) lim = 1;
    if (lim > ENTRIES) lim = ENTRIES;
    return lim;
  endfunction

  task automatic age_frames(input int unsigned lim, input int unsigned skip);
    for (int unsigned k = 0; k < lim; k++) begin
      if (k != skip && frame_used[k] && frame_age[k] != AGE_MAX) frame_age[k]++;
    end
  endtask

  task automatic predict_reference(input logic [PAGE_W-1:0] page, output page_result_t res);
    logic [PAGE_W-1:0] key;
    logic [AGE_W-1:0]  best;
    int unsigned       lim;
    int unsigned       slot;
    logic              hit;
    key  = page & PAGE_MASK;
    lim  = frames_in_use();
    hit  = 1'b0;
    slot = 0;
    res  = '0;
    for (int unsigned k = 0; k < lim; k++) begin
      if (!hit && frame_used[k] && frame_page[k] == key) begin
        hit  = 1'b1;
        slot = k;
      end
    end
    if (hit) begin
      age_frames(lim, slot);
      frame_age[slot] = '0;
    end else begin
      if (fill_level < lim) begin
        slot = fill_level;
        age_frames(lim, slot);
        fill_level++;
      end else begin
        // Age everything first, then take the oldest, lowest index on a tie.
        age_frames(lim, lim);
        best = '0;
        slot = 0;
        for (int unsigned k = 0; k < lim; k++) begin
          if (frame_age[k] > best) begin
            best = frame_age[k];
            slot = k;
          end
        end
        res.evicted = frame_used[slot];
      end
      frame_page[slot] = key;
      frame_used[slot] = 1'b1;
      frame_age[slot]  = '0;
      if (faults_seen != TOTAL_MAX) faults_seen++;
    end
    res.fault = !hit;
    res.slot  = SLOT_OUT_W'(slot);
    res.total = faults_seen;
  endtask

  function automatic int check_field(input string label, input logic [TOTAL_W-1:0] want,
                                     input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    page_result_t next_ref;
    int errs;
    errs = 0;
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) begin
        frame_page[k] = '0;
        frame_used[k] = 1'b0;
        frame_age[k]  = '0;
      end
      fill_level  = 0;
      faults_seen = '0;
      active_cfg  = ACTIVE_RESET;
      expected_refs.delete();
      mismatches <= 0;
    end else begin
      if (out_strobe !== 1'b0) begin
        if (expected_refs.size() == 0) begin
          $display("%0t: result with no reference pending: fault %0b slot %0d evicted %0b total %0d",
                   $time, out_fault, out_slot, out_evicted, out_fault_total);
          errs++;
        end else begin
          want = expected_refs.pop_front();
          errs += check_field("strobe", 1, TOTAL_W'(out_strobe));
          errs += check_field("fault", TOTAL_W'(want.fault), TOTAL_W'(out_fault));
          errs += check_field("slot", TOTAL_W'(want.slot), TOTAL_W'(out_slot));
          errs += check_field("evicted", TOTAL_W'(want.evicted), TOTAL_W'(out_evicted));
          errs += check_field("fault_total", want.total, out_fault_total);
        end
      end
      if (cfg_wr_en === 1'b1) active_cfg = cfg_wr_data;
      if (start === 1'b1 && busy === 1'b0) begin
        predict_reference(in_page_number, next_ref);
        expected_refs.push_back(next_ref);
      end
      mismatches <= mismatches + errs;
    end
    outstanding <= expected_refs.size();
  end

endmodule

// ===== tb/sv/lru_page_replacement_unit_test.sv =====
// Testbench top for the LRU page replacement unit: clock, reset, reference
// stimulus, configuration writes, watchdog and verdict.
// Depends on lpr_pkg, lru_page_replacement_unit and lru_page_replacement_checker.
module lru_page_replacement_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lpr_pkg::*;

  localparam int ENTRIES       = 16;
  localparam int PAGE_BITS     = 16;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
  localparam int POOL_SIZE     = 24;
  localparam int PHASE_REFS    = 75;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  start          = 1'b0;
  logic [PAGE_W-1:0]     in_page_number = '0;
  logic                  cfg_wr_en      = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data    = '0;
  logic                  busy;
  logic                  out_strobe;
  logic                  out_fault;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic                  out_evicted;
  logic [TOTAL_W-1:0]    out_fault_total;
  int                    mismatches;
  int                    outstanding;
  int                    quiet_cycles;
  int                    idle_pct;
  logic [PAGE_W-1:0]     page_pool [POOL_SIZE];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lru_page_replacement_unit #(
    .ENTRIES  (ENTRIES),
    .PAGE_BITS(PAGE_BITS)
  ) uut (.*);

  lru_page_replacement_checker #(
    .ENTRIES  (ENTRIES),
    .PAGE_BITS(PAGE_BITS)
  ) u_checker (.*);

  // Hold start and the page until the unit takes the transaction.
  task automatic issue_reference(input logic [PAGE_W-1:0] page);
    in_page_number <= page;
    start          <= 1'b1;
    forever begin
      @(negedge clk);
      if (busy === 1'b0) break;
    end
    @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || busy !== 1'b0);
    @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_strobe || cfg_wr_en) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [PAGE_W-1:0] page;
    int                pool_span;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PAGE_W'($urandom);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Three frames filled in order, then frame 1 left older than frame 0.
    write_config(CFG_W'(3));
    issue_reference(16'h0000);
    issue_reference(16'hFFFF);
    issue_reference(16'h1234);
    issue_reference(16'hFFFF);
    issue_reference(16'h0000);
    // Keep hitting frame 2 so frame 1 stays the oldest.
    repeat (8) issue_reference(16'h1234);
    // Miss on a full table: replace the oldest frame.
    issue_reference(16'h8000);

    // Zero active frames behaves as a single frame.
    write_config(CFG_W'(0));
    issue_reference(16'h4000);
    issue_reference(16'h4000);
    issue_reference(16'h0001);

    // Oversized count clamps to the table; filling resumes past frame 2.
    write_config(CFG_W'(31));
    issue_reference(16'h7FFF);
    issue_reference(16'h5555);
    issue_reference(16'hAAAA);
    issue_reference(16'h00FF);
    issue_reference(16'h0001);

    // Shrink the table: pages in upper frames no longer match.
    write_config(CFG_W'(2));
    issue_reference(16'h5555);
    issue_reference(16'hAAAA);

    // Grow it again: the lower duplicate wins the hit.
    write_config(CFG_W'(16));
    issue_reference(16'h5555);
    issue_reference(16'hFF00);
    issue_reference(16'h7FFF);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 50;
        2: idle_pct = 0;
        default: idle_pct = 19;
      endcase
      case (phase)
        0: write_config(CFG_W'(16));
        1: write_config(CFG_W'(1));
        2: write_config(CFG_W'(4));
        4: write_config(CFG_W'(31));
        5: write_config(CFG_W'(2));
        6: write_config(CFG_W'(8));
        default: write_config(CFG_W'($urandom_range(0, 31)));
      endcase
      for (int i = 0; i < POOL_SIZE; i++) begin
        if ($urandom_range(0, 3) == 0) page_pool[i] = PAGE_W'($urandom);
      end
      pool_span = $urandom_range(1, POOL_SIZE);
      for (int n = 0; n < PHASE_REFS; n++) begin
        // Mostly a working set so hits and replacements interleave.
        if ($urandom_range(0, 9) < 7) page = page_pool[$urandom_range(0, pool_span - 1)];
        else page = PAGE_W'($urandom);
        issue_reference(page);
        if ($urandom_range(0, 49) == 0) wait_drained();
        else if ($urandom_range(1, 100) <= idle_pct) pause_sender($urandom_range(1, 24));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lpr_pkg.sv
design/lpr_cell.sv
design/lpr_ctrl.sv
design/lru_page_replacement_unit.sv
tb/sv/lru_page_replacement_checker.sv
tb/sv/lru_page_replacement_unit_test.sv
